[design/bhdrl_pkg.sv]
// ----------------------------------------------------------------------------
// bhdrl_pkg
// Shared types and constants for the button hold debouncer with press
// rate limit.
// ----------------------------------------------------------------------------
`default_nettype none

package bhdrl_pkg;

  localparam int NumButtons = 3;
  localparam int TimeBits   = 32;
  localparam int CfgWidth   = 16;
  localparam int IdxWidth   = 2;

  typedef logic [TimeBits-1:0] time_t;
  typedef logic [IdxWidth-1:0] btn_idx_t;

  typedef enum logic {
    CMD_POLL = 1'b0,
    CMD_ACK  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_DEBOUNCE_WINDOW = 2'd0,
    REG_MIN_PRESS_GAP   = 2'd1,
    REG_SAFE_BUTTON     = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic        cmd;
    btn_idx_t    button_index;
    logic        level_down;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic     press_event;
    btn_idx_t event_button;
    logic     safe_pending;
    logic     stable_level;
  } out_item_t;

  typedef struct packed {
    logic [15:0] debounce_window_ms;
    logic [15:0] min_press_gap_ms;
    btn_idx_t    safe_button_index;
  } cfg_t;

endpackage

`default_nettype wire

[design/bhdrl_if.sv]
// ----------------------------------------------------------------------------
// bhdrl_in_if / bhdrl_out_if
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface bhdrl_in_if;
  logic                valid;
  logic                ready;
  bhdrl_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bhdrl_out_if;
  logic                 valid;
  logic                 ready;
  bhdrl_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/button_hold_debounce_rate_limit_top.sv]
// ----------------------------------------------------------------------------
// button_hold_debounce_rate_limit_top
// Path: an input transfer passes the input register, then the result
//   register, before its result transfer.
// Throughput: one item per cycle unless the receiver stalls results.
// Reset: asynchronous, active low; all button state and the safe flag clear,
//   configuration returns to 20 ms window, 100 ms gap, safe button 1.
// ----------------------------------------------------------------------------
`default_nettype none

module button_hold_debounce_rate_limit_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [1:0]                     cfg_idx_i,
  input  wire logic [bhdrl_pkg::CfgWidth-1:0] cfg_wdata_i,
  bhdrl_in_if.sink                            in_i,
  bhdrl_out_if.source                         out_o
);
  import bhdrl_pkg::*;

  cfg_t      cfg;
  in_item_t  item_q;
  logic      item_vld_q;
  out_item_t res, res_q;
  logic      res_vld_q;
  logic      advance;

  assign advance    = item_vld_q && (!res_vld_q || out_o.ready);
  assign in_i.ready = !item_vld_q || advance;

  bhdrl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bhdrl_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (in_i.ready) item_vld_q <= in_i.valid;
      if (advance) res_vld_q <= 1'b1;
      else if (out_o.ready) res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) item_q <= in_i.data;
    if (advance) res_q <= res;
  end

  assign out_o.valid = res_vld_q;
  assign out_o.data  = res_q;

  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> item_vld_q && res_vld_q && !out_o.ready)
    else $error("input stalled without cause");

  a_advance_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_vld_q)
    else $error("result lost");

  a_press_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_q.press_event |-> res_q.stable_level)
    else $error("press result without down level");

endmodule

`default_nettype wire

[design/bhdrl_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bhdrl_cfg_regs
// Configuration registers: debounce window, minimum press gap, safe button.
// ----------------------------------------------------------------------------
`default_nettype none

module bhdrl_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [1:0]                     cfg_idx_i,
  input  wire logic [bhdrl_pkg::CfgWidth-1:0] cfg_wdata_i,
  output bhdrl_pkg::cfg_t                     cfg_o
);
  import bhdrl_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_window_ms <= 16'd20;
      cfg_q.min_press_gap_ms   <= 16'd100;
      cfg_q.safe_button_index  <= IdxWidth'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE_WINDOW: cfg_q.debounce_window_ms <= cfg_wdata_i[15:0];
        REG_MIN_PRESS_GAP:   cfg_q.min_press_gap_ms   <= cfg_wdata_i[15:0];
        REG_SAFE_BUTTON:     cfg_q.safe_button_index  <= cfg_wdata_i[IdxWidth-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[design/bhdrl_core.sv]
// ----------------------------------------------------------------------------
// bhdrl_core
// Per-button debounce state, press gap check and safe-pending flag.
// One result per cycle from the registered item, stored on step_i.
// ----------------------------------------------------------------------------
`default_nettype none

module bhdrl_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire bhdrl_pkg::in_item_t  item_i,
  input  wire bhdrl_pkg::cfg_t      cfg_i,
  output bhdrl_pkg::out_item_t res_o
);
  import bhdrl_pkg::*;

  logic  cand_lvl_q  [NumButtons];
  logic  acc_lvl_q   [NumButtons];
  time_t cand_time_q [NumButtons];
  time_t last_time_q [NumButtons];
  logic  safe_q, safe_d;

  logic     btn_ok;
  btn_idx_t idx;
  time_t    now;
  logic     cand_lvl, acc_lvl;
  time_t    cand_time, last_time;
  logic     held, limited;
  logic     upd_cand, upd_acc, press;

  assign idx    = item_i.button_index;
  assign now    = item_i.now_ms[TimeBits-1:0];
  assign btn_ok = int'(idx) < NumButtons;

  always_comb begin
    cand_lvl  = btn_ok ? cand_lvl_q[idx]  : 1'b0;
    acc_lvl   = btn_ok ? acc_lvl_q[idx]   : 1'b0;
    cand_time = btn_ok ? cand_time_q[idx] : '0;
    last_time = btn_ok ? last_time_q[idx] : '0;

    held    = (now - cand_time) >= TimeBits'(cfg_i.debounce_window_ms);
    limited = (last_time != '0) &&
              ((now - last_time) < TimeBits'(cfg_i.min_press_gap_ms));

    upd_cand = 1'b0;
    upd_acc  = 1'b0;
    press    = 1'b0;
    safe_d   = safe_q;

    if (item_i.cmd == CMD_ACK) begin
      if (idx == cfg_i.safe_button_index) safe_d = 1'b0;
    end else if (btn_ok) begin
      if (item_i.level_down != cand_lvl) begin
        upd_cand = 1'b1;
      end else if (held && (item_i.level_down != acc_lvl)) begin
        upd_acc = 1'b1;
        if (item_i.level_down && !limited) begin
          press = 1'b1;
          if (idx == cfg_i.safe_button_index) safe_d = 1'b1;
        end
      end
    end

    res_o.press_event  = press;
    res_o.event_button = idx;
    res_o.safe_pending = safe_d;
    res_o.stable_level = upd_acc ? item_i.level_down : acc_lvl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumButtons; i++) begin
        cand_lvl_q[i]  <= 1'b0;
        acc_lvl_q[i]   <= 1'b0;
        cand_time_q[i] <= '0;
        last_time_q[i] <= '0;
      end
      safe_q <= 1'b0;
    end else if (step_i) begin
      safe_q <= safe_d;
      if (upd_cand) begin
        cand_lvl_q[idx]  <= item_i.level_down;
        cand_time_q[idx] <= now;
      end
      if (upd_acc) acc_lvl_q[idx] <= item_i.level_down;
      if (press) last_time_q[idx] <= now;
    end
  end

  a_press_is_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.press_event |-> res_o.stable_level && btn_ok)
    else $error("press without accepted down level");

  a_safe_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.press_event && (idx == cfg_i.safe_button_index) |=> safe_q)
    else $error("safe flag not raised");

  a_ack_no_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (item_i.cmd == CMD_ACK) |-> !res_o.press_event)
    else $error("press on acknowledge");

  a_press_updates_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && press |=> last_time_q[$past(idx)] == $past(now))
    else $error("last press time not recorded");

endmodule

`default_nettype wire

[bench/button_hold_debounce_rate_limit_top_test.sv]
// ----------------------------------------------------------------------------
// button_hold_debounce_rate_limit_top_test
// Drives poll samples and event acknowledgements into the debouncer, keeps
// its own copy of the per-button hold and rate-limit state to predict every
// report, and compares each result transfer field by field. Covers wrapped
// timestamps, out-of-range buttons, register extremes, random sender bursts,
// receiver stall patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module button_hold_debounce_rate_limit_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bhdrl_pkg::*;

  localparam int StallLimit = 2000;
  localparam int HoldCycles = 200;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [1:0]          cfg_idx_i;
  logic [CfgWidth-1:0] cfg_wdata_i;

  bhdrl_in_if  in_if ();
  bhdrl_out_if out_if ();

  button_hold_debounce_rate_limit_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #4 clk_i = ~clk_i;

  // debouncer state mirror
  logic        cand_lvl [NumButtons];
  logic        acc_lvl  [NumButtons];
  time_t       cand_t   [NumButtons];
  time_t       last_t   [NumButtons];
  logic        safe_flag;
  logic [15:0] window_ms;
  logic [15:0] gap_ms;
  btn_idx_t    safe_btn;

  out_item_t   button_reports[$];
  int          mismatches;
  int          idle_cycles;
  int          burst_left;
  bit          pace_on;
  bit          hold_req;
  time_t       clock_ms;
  bit          true_lvl [NumButtons];

  function automatic out_item_t debounce_step(in_item_t it);
    out_item_t r;
    time_t     since_cand;
    time_t     since_press;
    int        b;
    r = '0;
    r.event_button = it.button_index;
    b = int'(it.button_index);
    if (it.cmd == CMD_ACK) begin
      if (it.button_index == safe_btn) safe_flag = 1'b0;
    end else if (b < NumButtons) begin
      since_cand = it.now_ms - cand_t[b];
      if (it.level_down != cand_lvl[b]) begin
        cand_lvl[b] = it.level_down;
        cand_t[b]   = it.now_ms;
      end else if (since_cand >= time_t'(window_ms) && it.level_down != acc_lvl[b]) begin
        acc_lvl[b] = it.level_down;
        if (it.level_down) begin
          since_press = it.now_ms - last_t[b];
          if (last_t[b] == '0 || since_press >= time_t'(gap_ms)) begin
            last_t[b]     = it.now_ms;
            r.press_event = 1'b1;
            if (it.button_index == safe_btn) safe_flag = 1'b1;
          end
        end
      end
    end
    if (b < NumButtons) r.stable_level = acc_lvl[b];
    r.safe_pending = safe_flag;
    return r;
  endfunction

  function automatic in_item_t make_item(cmd_e c, int b, bit lvl, time_t t);
    in_item_t it;
    it.cmd          = c;
    it.button_index = btn_idx_t'(b);
    it.level_down   = lvl;
    it.now_ms       = t;
    return it;
  endfunction

  // mostly bouncing but well-formed sample streams, some acks and noise
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    int       b;
    pick = $urandom_range(99);
    it   = '0;
    if (pick < 8) begin
      it.cmd          = CMD_ACK;
      it.button_index = $urandom_range(1) ? safe_btn : btn_idx_t'($urandom_range(3));
      it.level_down   = 1'($urandom_range(1));
      it.now_ms       = $urandom;
    end else if (pick < 12) begin
      it.cmd          = CMD_POLL;
      it.button_index = btn_idx_t'($urandom_range(3));
      it.level_down   = 1'($urandom_range(1));
      it.now_ms       = $urandom;
    end else begin
      b = $urandom_range(NumButtons - 1);
      if ($urandom_range(15) == 0) true_lvl[b] = !true_lvl[b];
      clock_ms += time_t'($urandom_range(0, int'(window_ms) / 3 + 2));
      if ($urandom_range(9) == 0)
        clock_ms += time_t'($urandom_range(0, int'(gap_ms) + int'(window_ms) + 10));
      it.cmd          = CMD_POLL;
      it.button_index = btn_idx_t'(b);
      it.level_down   = true_lvl[b] ^ ($urandom_range(9) == 0);
      it.now_ms       = clock_ms;
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    button_reports.push_back(debounce_step(it));
    if (pace_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (button_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(logic [15:0] win, logic [15:0] gap, btn_idx_t safe);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_DEBOUNCE_WINDOW;
    cfg_wdata_i <= win;
    @(posedge clk_i);
    cfg_idx_i   <= REG_MIN_PRESS_GAP;
    cfg_wdata_i <= gap;
    @(posedge clk_i);
    cfg_idx_i   <= REG_SAFE_BUTTON;
    cfg_wdata_i <= CfgWidth'(safe);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    window_ms = win;
    gap_ms    = gap;
    safe_btn  = safe;
  endtask

  // reset settings: 20 ms window, 100 ms gap, safe button 1
  task automatic test_directed();
    send_item(make_item(CMD_POLL, 0, 1'b1, 32'hFFFF_FFEC));
    send_item(make_item(CMD_POLL, 0, 1'b1, 32'h0000_0000));  // press across wrap at 0
    send_item(make_item(CMD_POLL, 0, 1'b0, 32'd5));
    send_item(make_item(CMD_POLL, 0, 1'b0, 32'd25));
    send_item(make_item(CMD_POLL, 0, 1'b1, 32'd26));
    send_item(make_item(CMD_POLL, 0, 1'b1, 32'd46));         // zero last time: no limit
    send_item(make_item(CMD_POLL, 0, 1'b0, 32'd50));
    send_item(make_item(CMD_POLL, 0, 1'b0, 32'd70));
    send_item(make_item(CMD_POLL, 0, 1'b1, 32'd71));
    send_item(make_item(CMD_POLL, 0, 1'b1, 32'd91));         // rate limited
    send_item(make_item(CMD_POLL, 1, 1'b1, 32'd100));
    send_item(make_item(CMD_POLL, 1, 1'b1, 32'd120));        // safe flag up
    send_item(make_item(CMD_ACK, 0, 1'b1, 32'hFFFF_FFFF));
    send_item(make_item(CMD_POLL, 3, 1'b1, 32'hFFFF_FFFF));
    send_item(make_item(CMD_ACK, 1, 1'b0, 32'd0));
  endtask

  task automatic test_config_extremes();
    drain();
    set_config(16'd0, 16'd0, 2'd2);
    send_item(make_item(CMD_POLL, 2, 1'b1, 32'd5));
    send_item(make_item(CMD_POLL, 2, 1'b1, 32'd5));
    send_item(make_item(CMD_POLL, 2, 1'b0, 32'd5));
    send_item(make_item(CMD_POLL, 2, 1'b0, 32'd5));
    send_item(make_item(CMD_POLL, 2, 1'b1, 32'd5));
    send_item(make_item(CMD_POLL, 2, 1'b1, 32'd5));
    drain();
    set_config(16'hFFFF, 16'hFFFF, 2'd3);
    send_item(make_item(CMD_ACK, 3, 1'b0, 32'd0));           // out-of-range safe index ack
    send_item(make_item(CMD_POLL, 1, 1'b1, 32'd100));
    send_item(make_item(CMD_POLL, 1, 1'b1, 32'd65634));
    send_item(make_item(CMD_POLL, 1, 1'b1, 32'd65635));
    send_item(make_item(CMD_ACK, 1, 1'b1, 32'd7));
  endtask

  task automatic test_backpressure();
    int k;
    drain();
    set_config(16'd20, 16'd100, 2'd1);
    clock_ms = $urandom;
    pace_on  = 1'b0;
    hold_req = 1'b1;
    for (k = 0; k < 40; k++) send_item(random_item());
    pace_on = 1'b1;
  endtask

  task automatic test_random_phases();
    int phase;
    int k;
    for (phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        0: set_config(16'd20, 16'd100, 2'd1);
        1: set_config(16'd0, 16'd0, 2'd0);
        2: set_config(16'hFFFF, 16'hFFFF, 2'd2);
        3: set_config(16'($urandom_range(200)), 16'($urandom_range(1000)), 2'd3);
        default: set_config(16'($urandom), 16'($urandom), btn_idx_t'($urandom_range(3)));
      endcase
      clock_ms = ($urandom_range(2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 300000)
                                          : time_t'($urandom);
      for (k = 0; k < 170; k++) send_item(random_item());
    end
  endtask

  always @(posedge clk_i) begin : check_reports
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (button_reports.size() == 0) begin
        $error("result transfer with no report pending");
        mismatches++;
      end else begin
        want = button_reports.pop_front();
        if (out_if.data.press_event !== want.press_event) begin
          $error("press_event: expected %0d, got %0d", want.press_event,
                 out_if.data.press_event);
          mismatches++;
        end
        if (out_if.data.event_button !== want.event_button) begin
          $error("event_button: expected %0d, got %0d", want.event_button,
                 out_if.data.event_button);
          mismatches++;
        end
        if (out_if.data.safe_pending !== want.safe_pending) begin
          $error("safe_pending: expected %0d, got %0d", want.safe_pending,
                 out_if.data.safe_pending);
          mismatches++;
        end
        if (out_if.data.stable_level !== want.stable_level) begin
          $error("stable_level: expected %0d, got %0d", want.stable_level,
                 out_if.data.stable_level);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("button_hold_debounce_rate_limit_top_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: rotating stall pattern, plus one long hold-off on request
  initial begin : sink_ctrl
    logic [15:0] pattern;
    int          step;
    int          held;
    out_if.ready = 1'b0;
    pattern      = '1;
    step         = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        for (held = 0; held < HoldCycles; held++) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (step == 0) pattern = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
        out_if.ready <= pattern[step[3:0]];
        step = (step + 1) % 64;
      end
    end
  end

  initial begin
    int b;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_DEBOUNCE_WINDOW;
    cfg_wdata_i  = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    mismatches   = 0;
    idle_cycles  = 0;
    burst_left   = 0;
    pace_on      = 1'b1;
    hold_req     = 1'b0;
    clock_ms     = '0;
    for (b = 0; b < NumButtons; b++) begin
      cand_lvl[b] = 1'b0;
      acc_lvl[b]  = 1'b0;
      cand_t[b]   = '0;
      last_t[b]   = '0;
      true_lvl[b] = 1'b0;
    end
    safe_flag = 1'b0;
    window_ms = 16'd20;
    gap_ms    = 16'd100;
    safe_btn  = 2'd1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random_phases();
    drain();
    if (mismatches == 0 && button_reports.size() == 0) begin
      $display("button_hold_debounce_rate_limit_top_test OK");
    end else begin
      $display("button_hold_debounce_rate_limit_top_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
